[sv/sadtl_pkg.sv]
package sadtl_pkg;

    localparam int FRAME_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int MAX_SPAN    = 128;
    localparam int NUM_CELLS   = 2 * MAX_SPAN - 1;
    localparam int MAX_VECTORS = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ERR_W       = 24;
    localparam int DELAY_W     = 26;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_SPAN   = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_VLEN   = 2'd3;

    typedef struct packed {
        logic signed [15:0] ref_sample;
        logic signed [15:0] other_sample;
        logic               last_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [9:0]  delay_whole;
        logic [23:0]        match_error;
        logic               last_of_frame;
        logic               frame_overflow;
    } t_out_res;

    // Control broadcast to every cell of the shift accumulator row.
    typedef struct packed {
        logic clr;        // clear the accumulator
        logic shift_data; // take the neighbor's sample
        logic acc_en;     // add the absolute difference
        logic shift_acc;  // take the neighbor's accumulator
    } t_cell_ctl;

endpackage

[sv/sad_delay_tracking_loop_core.sv]
// SAD delay tracking loop. Paired reference and other samples are taken one
// request per cycle into two 1024-entry frame memories until a request with
// last_sample set. The block then walks the frame in vectors of
// vector_length samples and returns one result per vector, up to 64. For each
// vector the other window is placed at the vector start minus the whole part
// of the delay, and a row of 255 shift accumulator cells forms all left and
// right sums of absolute differences at once while the other samples stream
// through the row. A vector that is evaluated goes through the window check,
// 3*span - 2 memory reads feeding the row, a drain step for the last sum to
// settle, 2*span - 1 sums shifted out for the minimum search, then the gain
// multiply, the update and the result, which holds while it is stalled; a
// vector whose windows do not lie inside the frame goes from the window
// check straight to the result. The frame memories have one read port each,
// which sets the feed length. While results are being produced no input
// request is taken. The user writes configuration through a plain write
// port only while the block is idle; the block itself does not enforce it.
module sad_delay_tracking_loop_core
    import sadtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_FEED  = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_UPD   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [8:0]  r_period;
    logic [7:0]  r_span;
    logic [16:0] r_gain;
    logic [10:0] r_vlen;

    // Frame and loop state.
    logic [FILL_W-1:0]        r_fill;
    logic                     r_ovf;
    logic signed [DELAY_W-1:0] r_delay;
    logic [ERR_W-1:0]         r_last_err;

    // Sequencer registers.
    logic [5:0]   r_k;
    logic [10:0]  r_m;
    logic         r_last;
    logic [10:0]  r_base;
    logic [8:0]   r_j;
    logic         r_rd_v;
    logic         r_rd_acc;
    logic [7:0]   r_c;
    logic [ERR_W-1:0] r_min_l;
    logic [ERR_W-1:0] r_min_r;
    logic [6:0]   r_best_l;
    logic [6:0]   r_best_r;
    logic [ERR_W-1:0] r_err;
    logic         r_neg;
    logic [23:0]  r_prod;

    logic w_in_acc;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_LOAD);

    // Effective span and vector length.
    logic [7:0]  w_spanc;
    logic [10:0] w_vlenc;
    logic [8:0]  w_span2m2;
    logic [8:0]  w_jend;
    assign w_spanc   = (r_span > 8'(MAX_SPAN)) ? 8'(MAX_SPAN) : r_span;
    assign w_vlenc   = (r_vlen == 11'd0) ? 11'd1 : r_vlen;
    assign w_span2m2 = {w_spanc, 1'b0} - 9'd2;
    assign w_jend    = 9'({w_spanc, 1'b0}) + 9'(w_spanc) - 9'd3;

    // Window placement check for the current vector.
    logic signed [13:0] w_d;
    logic signed [13:0] w_sp;
    logic signed [13:0] w_fill;
    logic signed [13:0] w_mm;
    logic               w_ok;
    logic [11:0]        w_next_m;
    always_comb begin
        w_sp     = $signed({6'd0, w_spanc});
        w_fill   = $signed({3'd0, r_fill});
        w_mm     = $signed({3'd0, r_m});
        w_d      = w_mm - 14'($signed(r_delay[DELAY_W-1:16]));
        w_ok     = (w_spanc != 8'd0) && (w_d >= w_sp)
                && (w_d + w_sp + w_sp - 14'sd1 <= w_fill)
                && (w_mm + w_sp <= w_fill);
        w_next_m = {1'b0, r_m} + {1'b0, w_vlenc};
    end

    // Frame memories.
    logic [ADDR_W-1:0]      w_oth_raddr;
    logic [ADDR_W-1:0]      w_ref_raddr;
    logic [SAMPLE_BITS-1:0] w_oth_rdata;
    logic [SAMPLE_BITS-1:0] w_ref_rdata;
    logic                   w_we;
    logic [8:0]             w_ref_off;

    assign w_we        = w_in_acc && !r_fill[ADDR_W];
    assign w_oth_raddr = ADDR_W'(r_base + 11'(r_j));
    assign w_ref_off   = r_j - w_span2m2;
    assign w_ref_raddr = ADDR_W'(r_m + 11'(w_ref_off));

    sadtl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in_req.ref_sample),
        .i_raddr (w_ref_raddr),
        .o_rdata (w_ref_rdata)
    );

    sadtl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_DEPTH)) u_oth_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in_req.other_sample),
        .i_raddr (w_oth_raddr),
        .o_rdata (w_oth_rdata)
    );

    // Row of shift accumulator cells. Other samples enter at cell 0 and move
    // up the row; the reference sample is shared by all cells. After the feed
    // cell c holds the sum for offset span-1-c: left shifts on the low cells,
    // right shifts above, shift zero in cell span-1. The sums then leave the
    // row through cell 0, one per cycle.
    t_cell_ctl w_ctl;
    assign w_ctl.clr        = (r_state == S_CHECK);
    assign w_ctl.shift_data = r_rd_v;
    assign w_ctl.acc_en     = r_rd_v && r_rd_acc;
    assign w_ctl.shift_acc  = (r_state == S_SCAN);

    logic signed [SAMPLE_BITS-1:0] w_cdata [NUM_CELLS];
    logic [ERR_W-1:0]              w_cacc  [NUM_CELLS];

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_din;
        logic [ERR_W-1:0]              w_ain;
        if (c == 0) begin : g_head
            assign w_din = w_oth_rdata;
        end else begin : g_body
            assign w_din = w_cdata[c-1];
        end
        if (c == NUM_CELLS - 1) begin : g_tail
            assign w_ain = '0;
        end else begin : g_next
            assign w_ain = w_cacc[c+1];
        end
        sadtl_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_ref  (w_ref_rdata),
            .i_data (w_din),
            .i_acc  (w_ain),
            .o_data (w_cdata[c]),
            .o_acc  (w_cacc[c])
        );
    end

    // Minimum search over the sums leaving the row. Left shifts arrive in
    // falling order, so ties move to the smaller shift; right shifts arrive
    // in rising order, so only a strictly smaller sum replaces the best.
    logic [7:0]  w_sl;
    logic [7:0]  w_sr;
    logic [ERR_W-1:0] w_head;
    assign w_head = w_cacc[0];
    assign w_sl   = w_spanc - 8'd1 - r_c;
    assign w_sr   = r_c - (w_spanc - 8'd1);

    // Delay update.
    logic               w_take_l;
    logic signed [26:0] w_sum;
    logic signed [26:0] w_lim;
    logic               w_wrap;
    always_comb begin
        w_take_l = r_min_l < r_min_r;
        w_lim    = $signed({2'b00, r_period, 16'd0});
        w_sum    = r_neg ? (27'(r_delay) - $signed({3'b000, r_prod}))
                         : (27'(r_delay) + $signed({3'b000, r_prod}));
        w_wrap   = (w_sum > w_lim) || (w_sum < -w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_period   <= 9'd32;
            r_span     <= 8'd16;
            r_gain     <= 17'd6554;
            r_vlen     <= 11'd16;
            r_fill     <= '0;
            r_ovf      <= 1'b0;
            r_delay    <= '0;
            r_last_err <= '0;
            r_rd_v     <= 1'b0;
        end else begin
            // A read issued in the feed state is valid in the next cycle.
            r_rd_v <= (r_state == S_FEED);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PERIOD: r_period <= i_cfg_data[8:0];
                    REG_SPAN:   r_span   <= i_cfg_data[7:0];
                    REG_GAIN:   r_gain   <= i_cfg_data;
                    REG_VLEN:   r_vlen   <= i_cfg_data[10:0];
                    default:    ;
                endcase
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (!r_fill[ADDR_W]) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_req.last_sample) begin
                            r_k     <= '0;
                            r_m     <= '0;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_last <= (w_next_m >= {1'b0, r_fill}) || (r_k == 6'(MAX_VECTORS - 1));
                    r_base <= 11'(w_d - w_sp + 14'sd1);
                    r_j    <= '0;
                    r_state <= w_ok ? S_FEED : S_EMIT;
                end
                S_FEED: begin
                    r_rd_acc <= (r_j >= w_span2m2);
                    r_j      <= r_j + 9'd1;
                    if (r_j == w_jend) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_c     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_c < w_spanc) begin
                        if (r_c == 8'd0 || w_head <= r_min_l) begin
                            r_min_l  <= w_head;
                            r_best_l <= w_sl[6:0];
                        end
                    end
                    if (r_c >= w_spanc - 8'd1) begin
                        if (r_c == w_spanc - 8'd1 || w_head < r_min_r) begin
                            r_min_r  <= w_head;
                            r_best_r <= w_sr[6:0];
                        end
                    end
                    r_c <= r_c + 8'd1;
                    if (9'(r_c) == w_span2m2) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_err   <= w_take_l ? r_min_l : r_min_r;
                    r_neg   <= w_take_l;
                    r_prod  <= r_gain * (w_take_l ? r_best_l : r_best_r);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_last_err <= r_err;
                    r_delay    <= w_wrap ? '0 : w_sum[DELAY_W-1:0];
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        if (r_last) begin
                            r_fill  <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 6'd1;
                            r_m     <= w_next_m[10:0];
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // The result registers hold still while the result waits in S_EMIT.
    assign o_out_valid                = (r_state == S_EMIT);
    assign o_out_res.delay_whole      = r_delay[DELAY_W-1:16];
    assign o_out_res.match_error      = r_last_err;
    assign o_out_res.last_of_frame    = r_last;
    assign o_out_res.frame_overflow   = r_ovf;

endmodule

[sv/sadtl_ram.sv]
module sadtl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sadtl_cell.sv]
module sadtl_cell
    import sadtl_pkg::*;
(
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_ref,
    input  logic signed [SAMPLE_BITS-1:0] i_data,
    input  logic [ERR_W-1:0]              i_acc,
    output logic signed [SAMPLE_BITS-1:0] o_data,
    output logic [ERR_W-1:0]              o_acc
);

    logic signed [SAMPLE_BITS-1:0] r_data;
    logic [ERR_W-1:0]              r_acc;
    logic signed [SAMPLE_BITS:0]   w_diff;
    logic [SAMPLE_BITS:0]          w_abs;
    logic [ERR_W:0]                w_sum;

    // The difference is taken against the sample arriving this cycle.
    always_comb begin
        w_diff = {i_ref[SAMPLE_BITS-1], i_ref} - {i_data[SAMPLE_BITS-1], i_data};
        w_abs  = w_diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-w_diff) : w_diff;
        w_sum  = {1'b0, r_acc} + (ERR_W+1)'(w_abs);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_data) begin
            r_data <= i_data;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= w_sum[ERR_W] ? ERR_MAX : w_sum[ERR_W-1:0];
        end else if (i_ctl.shift_acc) begin
            r_acc <= i_acc;
        end
    end

    assign o_data = r_data;
    assign o_acc  = r_acc;

endmodule

[test/sad_delay_tracking_loop_checker.sv]
module sad_delay_tracking_loop_checker
    import sadtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_req     i_in_req,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_res    i_out_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copy of the block's state and registers.
    int          ref_mem [FRAME_DEPTH];
    int          oth_mem [FRAME_DEPTH];
    int unsigned fill_cnt;
    longint      delay_q16;
    logic [23:0] best_err;
    bit          dropped;
    int unsigned period_reg, span_reg, gain_reg, vlen_reg;

    t_out_res    vector_results [$];

    function automatic logic [23:0] window_sad(longint m, longint base, longint n);
        longint acc;
        longint diff;
        acc = 0;
        for (longint i = 0; i < n; i++) begin
            diff = longint'(ref_mem[(m + i) % FRAME_DEPTH]) - oth_mem[(base + i) % FRAME_DEPTH];
            acc += (diff < 0) ? -diff : diff;
        end
        return (acc > 64'hFFFFFF) ? ERR_MAX : acc[23:0];
    endfunction

    // One tracking step for the vector starting at m.
    function automatic void track_vector(longint m, longint n);
        longint      d;
        longint      best_l, best_r, offset, lim;
        logic [23:0] min_l, min_r, l, r;
        d = m - (delay_q16 >>> 16);
        best_l = 0;
        best_r = 0;
        min_l = '0;
        min_r = '0;
        if (n <= 0 || d < n || d + 2 * n - 1 > fill_cnt || m + n > fill_cnt)
            return;
        for (longint s = 0; s < n; s++) begin
            l = window_sad(m, d + s, n);
            r = window_sad(m, d - s, n);
            if (s == 0 || l < min_l) begin
                min_l = l;
                best_l = s;
            end
            if (s == 0 || r < min_r) begin
                min_r = r;
                best_r = s;
            end
        end
        if (min_l < min_r) begin
            best_err = min_l;
            offset = -best_l;
        end else begin
            best_err = min_r;
            offset = best_r;
        end
        delay_q16 += longint'(gain_reg) * offset;
        lim = longint'(period_reg) * 65536;
        if (delay_q16 > lim || delay_q16 < -lim)
            delay_q16 = 0;
    endfunction

    function automatic void take_sample(t_in_req req);
        longint   vlen, span, nvec;
        t_out_res res;
        if (fill_cnt < FRAME_DEPTH) begin
            ref_mem[fill_cnt] = req.ref_sample;
            oth_mem[fill_cnt] = req.other_sample;
            fill_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!req.last_sample)
            return;
        vlen = (vlen_reg == 0) ? 1 : vlen_reg;
        span = (span_reg > MAX_SPAN) ? MAX_SPAN : span_reg;
        nvec = (fill_cnt + vlen - 1) / vlen;
        if (nvec > MAX_VECTORS) nvec = MAX_VECTORS;
        if (nvec < 1) nvec = 1;
        for (longint k = 0; k < nvec; k++) begin
            track_vector(k * vlen, span);
            res.delay_whole    = 10'(delay_q16 >>> 16);
            res.match_error    = best_err;
            res.last_of_frame  = (k == nvec - 1);
            res.frame_overflow = dropped;
            vector_results.push_back(res);
        end
        fill_cnt = 0;
        dropped = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_out_res want;
        if (!i_rst_n) begin
            fill_cnt = 0;
            delay_q16 = 0;
            best_err = '0;
            dropped = 1'b0;
            period_reg = 32;
            span_reg = 16;
            gain_reg = 6554;
            vlen_reg = 16;
            vector_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PERIOD: period_reg = i_cfg_data[8:0];
                    REG_SPAN:   span_reg   = i_cfg_data[7:0];
                    REG_GAIN:   gain_reg   = i_cfg_data[16:0];
                    REG_VLEN:   vlen_reg   = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                take_sample(i_in_req);
            if (i_out_valid && !i_out_stall) begin
                if (vector_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: delay %0d error %0d last %0b ovf %0b",
                                 i_out_res.delay_whole, i_out_res.match_error,
                                 i_out_res.last_of_frame, i_out_res.frame_overflow);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = vector_results.pop_front();
                    if (i_out_res.delay_whole !== want.delay_whole
                        || i_out_res.match_error !== want.match_error
                        || i_out_res.last_of_frame !== want.last_of_frame
                        || i_out_res.frame_overflow !== want.frame_overflow) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp delay %0d err %0d last %0b ovf %0b, got delay %0d err %0d last %0b ovf %0b",
                                     want.delay_whole, want.match_error, want.last_of_frame,
                                     want.frame_overflow, i_out_res.delay_whole,
                                     i_out_res.match_error, i_out_res.last_of_frame,
                                     i_out_res.frame_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= vector_results.size();
    end

endmodule

[test/tb_sad_delay_tracking_loop_core.sv]
module tb_sad_delay_tracking_loop_core;
    import sadtl_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_req     in_req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_res    out_res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_PERIOD;
    logic [16:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    // When set, neither side inserts idle cycles.
    bit          quiet = 1'b0;
    // Per-frame switch for idle bursts on the request side.
    bit          gappy = 1'b0;
    int          random_items = 0;
    int          stall_left = 0;

    always #4 i_clk = ~i_clk;

    sad_delay_tracking_loop_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sad_delay_tracking_loop_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_res    (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side stalls in random bursts, with long quiet stretches
    // between them.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Hands one request to the block and returns at the edge that takes it.
    // The stall seen at the falling edge is the one the next rising edge uses.
    task automatic send_sample(logic signed [15:0] r, logic signed [15:0] o, logic last);
        if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= '{ref_sample: r, other_sample: o, last_sample: last};
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
    endtask

    // Sends a frame in which the other signal is the reference moved by a
    // few samples plus some noise, so the loop has something to lock onto.
    // Mode 0 is small-amplitude, mode 1 full scale, mode 2 unrelated noise.
    task automatic send_frame(int len, int mode);
        int lag;
        int amp;
        int noise;
        int base [0:1100];
        int o;
        lag = $urandom_range(0, 6) - 3;
        amp = (mode == 0) ? 200 : 32767;
        noise = $urandom_range(0, 3);
        gappy = $urandom_range(0, 1);
        for (int i = 0; i < len + 8; i++)
            base[i] = $urandom_range(0, 2 * amp) - amp;
        for (int i = 0; i < len; i++) begin
            if (mode == 2) begin
                o = $urandom_range(0, 65535) - 32768;
            end else begin
                o = base[i + 4 - lag] + $urandom_range(0, 2 * noise) - noise;
                if (o > 32767) o = 32767;
                if (o < -32768) o = -32768;
            end
            send_sample(16'(base[i + 4]), 16'(o), i == len - 1);
        end
        in_valid <= 1'b0;
    endtask

    // Writes all four registers on consecutive edges.
    task automatic set_regs(int period, int span, int gain, int vlen);
        int vals [4];
        vals = '{period, span, gain, vlen};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= 17'(vals[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Pause until every expected result has arrived, plus a short settle.
    // The first edge lets the pending count see the frame just sent.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int period, span, gain, vlen, len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two one-sample frames at the sample extremes, then a short
        // correlated frame that a two-wide search can evaluate.
        set_regs(32, 2, 65536, 4);
        send_sample(16'sh8000, 16'sh7fff, 1'b1);
        send_sample(16'sh7fff, 16'sh8000, 1'b1);
        in_valid <= 1'b0;
        drain();
        send_frame(12, 1);
        drain();

        // A wider search window over a longer frame.
        set_regs(511, 8, 65536, 12);
        send_frame(40, 0);
        drain();

        // Random settings, extremes included, each with a few frames.
        while (random_items < 30) begin
            case ($urandom_range(0, 5))
                0: period = 0;
                1: period = 2;
                2: period = 256;
                3: period = 511;
                default: period = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 6))
                0: span = 0;
                1: span = 1;
                2: span = 200;
                default: span = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 5))
                0: gain = 0;
                1: gain = 65536;
                2: gain = 131071;
                default: gain = $urandom_range(0, 131071);
            endcase
            case ($urandom_range(0, 7))
                0: vlen = 0;
                1: vlen = 1024;
                2: vlen = 2047;
                default: vlen = $urandom_range(1, 8);
            endcase
            set_regs(period, span, gain, vlen);
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(1, 16);
                send_frame(len, $urandom_range(0, 2));
                random_items += len;
            end
            drain();
        end

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        set_regs(16, 3, 32768, 5);
        repeat (2) send_frame($urandom_range(8, 12), $urandom_range(0, 1));
        drain();

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
